/* sv/wnps_pkg.sv */
// ----------------------------------------------------------------------------
// wnps_pkg
// Shared types, constants and helpers for the wildcard nibble pattern scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package wnps_pkg;

    // Default sizing, handed down to the top level parameters
    localparam int MAX_PATTERN_BYTES_DEF = 16;
    localparam int POSITION_BITS_DEF     = 48;

    // Fixed register layout
    localparam int PATTERN_SLOTS = 16;
    localparam int PATTERN_W     = 8 * PATTERN_SLOTS;
    localparam int CARE_W        = 2 * PATTERN_SLOTS;
    localparam int LEN_W         = 5;
    localparam int OCC_W         = 16;
    localparam int ADDR_W        = 64;
    localparam int CFG_INDEX_W   = 3;
    localparam int CFG_DATA_W    = 64;

    localparam logic [3:0]       NIBBLE_MASK = 4'hF;
    localparam logic [OCC_W-1:0] MATCH_COUNT_MAX = 16'hFFFF;

    // Register indexes on the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LOW  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_HIGH = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CARE_MASK    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LEN  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_OCCURRENCE   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_BASE_ADDR    = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_RESULT_OFS   = 3'd6;

    // One pending result between the scan stage and the output stage
    typedef struct packed {
        logic              found;
        logic [ADDR_W-1:0] start;
    } wnps_result_t;

    // Byte compare with per-nibble don't-care; care[1] high nibble, care[0] low
    function automatic logic byte_fits(input logic [7:0] data, input logic [7:0] pat,
                                       input logic [1:0] care);
        logic hi_miss;
        logic lo_miss;
        hi_miss = care[1] && (((data[7:4] ^ pat[7:4]) & NIBBLE_MASK) != 4'h0);
        lo_miss = care[0] && (((data[3:0] ^ pat[3:0]) & NIBBLE_MASK) != 4'h0);
        return !(hi_miss || lo_miss);
    endfunction

endpackage

`default_nettype wire

/* sv/wnps_match.sv */
// ----------------------------------------------------------------------------
// wnps_match
// Parallel window compare: every pattern byte against its window byte.
// ----------------------------------------------------------------------------
`default_nettype none

module wnps_match #(
    parameter int MAX_PATTERN_BYTES = wnps_pkg::MAX_PATTERN_BYTES_DEF,
    parameter int POSITION_BITS     = wnps_pkg::POSITION_BITS_DEF
) (
    input  wire logic [8*MAX_PATTERN_BYTES-1:0] window,      // entry 0 newest, lowest bits
    input  wire logic [wnps_pkg::PATTERN_W-1:0] pattern,
    input  wire logic [wnps_pkg::CARE_W-1:0]    care_mask,
    input  wire logic [wnps_pkg::LEN_W-1:0]     pattern_len,
    input  wire logic [POSITION_BITS-1:0]       bytes_seen,
    output logic                                match
);
    import wnps_pkg::*;

    logic [MAX_PATTERN_BYTES-1:0] fit;

    // Pattern byte k lines up with window entry len-1-k
    for (genvar k = 0; k < MAX_PATTERN_BYTES; k++) begin : g_byte
        logic [LEN_W-1:0] sel_idx;
        logic [7:0]       sel_byte;
        always_comb begin
            sel_idx  = pattern_len - LEN_W'(k + 1);
            sel_byte = 8'h00;
            for (int j = 0; j < MAX_PATTERN_BYTES; j++) begin
                if (sel_idx == LEN_W'(j)) begin
                    sel_byte = window[8*j +: 8];
                end
            end
        end
        assign fit[k] = (LEN_W'(k) >= pattern_len)
                     || byte_fits(sel_byte, pattern[8*k +: 8], care_mask[2*k +: 2]);
    end

    assign match = (pattern_len != '0)
                && (pattern_len <= LEN_W'(MAX_PATTERN_BYTES))
                && (bytes_seen >= POSITION_BITS'(pattern_len))
                && (&fit);

endmodule

`default_nettype wire

/* sv/wnps_result_pipe.sv */
// ----------------------------------------------------------------------------
// wnps_result_pipe
// Holding stage plus output register; forms the reported address.
// ----------------------------------------------------------------------------
`default_nettype none

module wnps_result_pipe (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       push,
    input  wire wnps_pkg::wnps_result_t     result,
    output logic                            push_ready,
    input  wire logic [wnps_pkg::ADDR_W-1:0] base_address,
    input  wire logic [wnps_pkg::ADDR_W-1:0] result_offset,
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic [wnps_pkg::ADDR_W-1:0]     m_tdata,     // [63:0] match_address
    output logic                            m_tuser      // [0] found
);
    import wnps_pkg::*;

    logic              hold_valid_reg;
    wnps_result_t      hold_reg;
    logic              out_valid_reg;
    logic              out_found_reg;
    logic [ADDR_W-1:0] out_addr_reg;
    logic [ADDR_W-1:0] addr_next;
    logic              advance;

    assign advance    = !out_valid_reg || m_tready;
    assign push_ready = !hold_valid_reg || advance;

    assign addr_next = hold_reg.found ? (base_address + result_offset + hold_reg.start)
                                      : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            hold_valid_reg <= push || (hold_valid_reg && !advance);
            if (advance) begin
                out_valid_reg <= hold_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            hold_reg <= result;
        end
        if (advance && hold_valid_reg) begin
            out_found_reg <= hold_reg.found;
            out_addr_reg  <= addr_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_addr_reg;
    assign m_tuser  = out_found_reg;

endmodule

`default_nettype wire

/* sv/wildcard_nibble_pattern_scanner_unit.sv */
// ----------------------------------------------------------------------------
// wildcard_nibble_pattern_scanner_unit
// Byte stream signature scan with per-nibble wildcards and occurrence select.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while the result output is not stalled; the
//   window compare is parallel. Result path: the holding stage loads a result
//   at the accepting edge, and the output register forms the address from it
//   once the output is free; a stalled output with a full holding stage drops s_tready.
// Reset: aresetn (synchronous, active low) clears the configuration registers,
//   the valid flags, the scan window and counters; the end of each stream returns the scan state to reset.
// ----------------------------------------------------------------------------
`default_nettype none

module wildcard_nibble_pattern_scanner_unit #(
    parameter int MAX_PATTERN_BYTES = wnps_pkg::MAX_PATTERN_BYTES_DEF,
    parameter int POSITION_BITS     = wnps_pkg::POSITION_BITS_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // Configuration write port
    input  wire logic                             cfg_wr_en,
    input  wire logic [wnps_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [wnps_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // Byte stream in
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [7:0]                       s_tdata,   // [7:0] data_byte
    input  wire logic                             s_tlast,   // last_byte
    // Result out
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [wnps_pkg::ADDR_W-1:0]           m_tdata,   // [63:0] match_address
    output logic                                  m_tuser    // [0] found
);
    import wnps_pkg::*;

    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

    // Configuration registers
    logic [PATTERN_W-1:0] pattern_reg;     // {high, low}
    logic [CARE_W-1:0]    care_reg;
    logic [LEN_W-1:0]     len_reg;
    logic [OCC_W-1:0]     occ_reg;
    logic [ADDR_W-1:0]    base_reg;
    logic [ADDR_W-1:0]    offset_reg;

    // Scan state
    logic [8*MAX_PATTERN_BYTES-1:0] window_reg, window_next, window_shift;
    logic [POSITION_BITS-1:0]       bytes_reg, bytes_next, bytes_inc;
    logic [OCC_W-1:0]               matches_reg, matches_next;
    logic                           done_reg, done_next;

    logic         accept;
    logic         match;
    logic         push;
    logic         push_ready;
    wnps_result_t result;

    assign s_tready = push_ready;
    assign accept   = s_tvalid && s_tready;

    // Hold configuration; the user must write only while the stream is quiet, the block does not enforce it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_reg <= '0;
            care_reg    <= '0;
            len_reg     <= '0;
            occ_reg     <= '0;
            base_reg    <= '0;
            offset_reg  <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_PATTERN_LOW:  pattern_reg[ADDR_W-1:0]         <= cfg_wdata;
                REG_PATTERN_HIGH: pattern_reg[PATTERN_W-1:ADDR_W] <= cfg_wdata;
                REG_CARE_MASK:    care_reg   <= cfg_wdata[CARE_W-1:0];
                REG_PATTERN_LEN:  len_reg    <= cfg_wdata[LEN_W-1:0];
                REG_OCCURRENCE:   occ_reg    <= cfg_wdata[OCC_W-1:0];
                REG_BASE_ADDR:    base_reg   <= cfg_wdata;
                REG_RESULT_OFS:   offset_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Window after taking the incoming byte: entry 0 is the newest
    if (MAX_PATTERN_BYTES > 1) begin : g_shift
        assign window_shift = {window_reg[8*(MAX_PATTERN_BYTES-1)-1:0], s_tdata};
    end else begin : g_single
        assign window_shift = s_tdata;
    end

    // Saturating byte position
    assign bytes_inc = (bytes_reg == POS_MAX) ? bytes_reg : bytes_reg + 1'b1;

    wnps_match #(
        .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES),
        .POSITION_BITS     (POSITION_BITS)
    ) u_match (
        .window      (window_shift),
        .pattern     (pattern_reg),
        .care_mask   (care_reg),
        .pattern_len (len_reg),
        .bytes_seen  (bytes_inc),
        .match       (match)
    );

    // Scan step for one accepted byte
    always_comb begin
        window_next  = window_reg;
        bytes_next   = bytes_reg;
        matches_next = matches_reg;
        done_next    = done_reg;
        push         = 1'b0;
        result.found = 1'b0;
        result.start = ADDR_W'(bytes_inc - POSITION_BITS'(len_reg));
        if (accept) begin
            if (!done_reg) begin
                window_next = window_shift;
                bytes_next  = bytes_inc;
                if (match) begin
                    if (matches_reg == occ_reg) begin
                        // requested occurrence: report and ignore the rest
                        push         = 1'b1;
                        result.found = 1'b1;
                        done_next    = 1'b1;
                    end else if (matches_reg != MATCH_COUNT_MAX) begin
                        matches_next = matches_reg + 1'b1;
                    end
                end
                // stream ends without the requested match: report not-found
                if (s_tlast && !push) begin
                    push = 1'b1;
                end
            end
            if (s_tlast) begin
                window_next  = '0;
                bytes_next   = '0;
                matches_next = '0;
                done_next    = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg  <= '0;
            bytes_reg   <= '0;
            matches_reg <= '0;
            done_reg    <= 1'b0;
        end else begin
            window_reg  <= window_next;
            bytes_reg   <= bytes_next;
            matches_reg <= matches_next;
            done_reg    <= done_next;
        end
    end

    wnps_result_pipe u_result (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .push          (push),
        .result        (result),
        .push_ready    (push_ready),
        .base_address  (base_reg),
        .result_offset (offset_reg),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser)
    );

endmodule

`default_nettype wire

/* dv/wildcard_nibble_pattern_scanner_unit_tb.sv */
// ----------------------------------------------------------------------------
// wildcard_nibble_pattern_scanner_unit_tb
// Self-checking bench for the nibble-wildcard byte signature scanner.
// Streams of bytes go in over the slave channel. A cycle-free model of the scan
// window, the match counter and the occurrence select predicts each found or
// not-found report, and every transfer on the master channel is compared with
// the oldest prediction. Both channels idle at random.
// ----------------------------------------------------------------------------

module wildcard_nibble_pattern_scanner_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wnps_pkg::*;

    localparam int SCAN_SLOTS    = MAX_PATTERN_BYTES_DEF;
    localparam int POS_W         = POSITION_BITS_DEF;
    localparam int DRAIN_CYCLES  = 6;        // margin for the result pipe to drain
    localparam int RANDOM_ITEMS  = 560;
    localparam int LIMIT_STREAM  = 64;       // bytes in the long gap-free stream
    localparam longint CYCLE_LIMIT = 40000;

    typedef struct packed {
        logic              found;
        logic [ADDR_W-1:0] addr;
    } scan_report_t;

    // ------------------------------------------------------------------
    // Clock, reset and DUT ports; every input starts at a known value
    // ------------------------------------------------------------------
    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [7:0]             s_tdata   = '0;   // [7:0] data_byte
    logic                   s_tlast   = 1'b0; // last_byte
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [ADDR_W-1:0]      m_tdata;          // [63:0] match_address
    logic                   m_tuser;          // [0] found

    always #4 aclk = ~aclk;

    wildcard_nibble_pattern_scanner_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // ------------------------------------------------------------------
    // Mirror of the register file (as the block masks it) and of the scan state
    // ------------------------------------------------------------------
    logic [63:0]        lo_r   = '0;
    logic [63:0]        hi_r   = '0;
    logic [CARE_W-1:0]  care_r = '0;
    logic [LEN_W-1:0]   len_r  = '0;
    logic [OCC_W-1:0]   occ_r  = '0;
    logic [ADDR_W-1:0]  base_r = '0;
    logic [ADDR_W-1:0]  ofs_r  = '0;

    logic [7:0]         win_q [SCAN_SLOTS] = '{default: 8'h00};  // entry 0 is newest
    logic [POS_W-1:0]   seen_q  = '0;
    logic [OCC_W-1:0]   count_q = '0;
    logic               done_q  = 1'b0;

    scan_report_t       reports_due [$];     // predicted reports, oldest first
    logic [7:0]         stream_q [$];        // bytes of the stream about to be sent
    bit                 tx_eager = 1'b0;     // sender skips its idle cycles
    bit                 rx_eager = 1'b0;     // receiver never stalls
    int                 mismatch_count = 0;
    longint             cycle_count = 0;

    function automatic logic [7:0] pattern_at(input int k);
        logic [8*PATTERN_SLOTS-1:0] row;
        row = {hi_r, lo_r};
        return row[8*k +: 8];
    endfunction

    // Advance the scan by one byte; return 1 when the byte produces a report
    function automatic bit scan_byte(input logic [7:0] b, input logic last,
                                     output scan_report_t r);
        bit         emit;
        bit         hit;
        int         i;
        int         k;
        logic [7:0] got;
        logic [7:0] want;
        logic [1:0] care;
        emit    = 1'b0;
        r.found = 1'b0;
        r.addr  = '0;
        if (!done_q) begin
            // Shift the window and count the byte, saturating at the top
            for (i = SCAN_SLOTS - 1; i > 0; i--) win_q[i] = win_q[i-1];
            win_q[0] = b;
            if (seen_q != '1) seen_q = seen_q + 1'b1;

            // Oldest byte of the window lines up with pattern byte 0
            hit = (len_r != 0) && (len_r <= SCAN_SLOTS) && (seen_q >= len_r);
            for (k = 0; hit && k < len_r; k++) begin
                got  = win_q[len_r - 1 - k];
                want = pattern_at(k);
                care = care_r[2*k +: 2];
                if (care[1] && got[7:4] != want[7:4]) hit = 1'b0;
                if (care[0] && got[3:0] != want[3:0]) hit = 1'b0;
            end

            if (hit) begin
                if (count_q == occ_r) begin
                    r.found = 1'b1;
                    r.addr  = base_r + (64'(seen_q) - 64'(len_r)) + ofs_r;
                    emit    = 1'b1;
                    done_q  = 1'b1;
                end else if (count_q != MATCH_COUNT_MAX) begin
                    count_q = count_q + 1'b1;
                end
            end

            // End of stream without the requested match: not-found at address 0
            if (last && !emit) emit = 1'b1;
        end

        // Every stream end returns the scan to its reset state
        if (last) begin
            for (i = 0; i < SCAN_SLOTS; i++) win_q[i] = 8'h00;
            seen_q  = '0;
            count_q = '0;
            done_q  = 1'b0;
        end
        return emit;
    endfunction

    // ------------------------------------------------------------------
    // Result side: random stalls, compare each transfer with the oldest report
    // ------------------------------------------------------------------
    task automatic flag_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $time, what);
        mismatch_count++;
    endtask

    always @(posedge aclk) begin : result_check
        scan_report_t want;
        int           rx_hold;
        if (!aresetn) begin
            rx_hold = 0;
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (reports_due.size() == 0) begin
                    flag_mismatch($sformatf("unexpected report found=%0b addr=%h",
                                            m_tuser, m_tdata));
                end else begin
                    want = reports_due.pop_front();
                    if (m_tuser !== want.found)
                        flag_mismatch($sformatf("found %0b, predicted %0b",
                                                m_tuser, want.found));
                    if (m_tdata !== want.addr)
                        flag_mismatch($sformatf("match_address %h, predicted %h",
                                                m_tdata, want.addr));
                end
                // Draw the stall that follows this transfer
                rx_hold = rx_eager ? 0 : $urandom_range(0, 3);
            end else if (rx_hold > 0) begin
                rx_hold--;
            end
            m_tready <= (rx_hold == 0);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus side
    // ------------------------------------------------------------------

    // Present one byte after a random idle gap and hold it until the transfer
    task automatic send_byte(input logic [7:0] b, input logic last);
        int           gap;
        scan_report_t r;
        gap = tx_eager ? 0 : $urandom_range(0, 3);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (scan_byte(b, last, r)) reports_due = {reports_due, r};
    endtask

    // Send stream_q as one stream, tlast on its final byte
    task automatic send_stream();
        int j;
        for (j = 0; j < stream_q.size(); j++)
            send_byte(stream_q[j], j == stream_q.size() - 1);
    endtask

    // Hold off until every predicted report has been seen, then let the pipe empty
    task automatic settle();
        s_tvalid <= 1'b0;
        while (reports_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        case (idx)
            REG_PATTERN_LOW:  lo_r   = value;
            REG_PATTERN_HIGH: hi_r   = value;
            REG_CARE_MASK:    care_r = value[CARE_W-1:0];
            REG_PATTERN_LEN:  len_r  = value[LEN_W-1:0];
            REG_OCCURRENCE:   occ_r  = value[OCC_W-1:0];
            REG_BASE_ADDR:    base_r = value;
            REG_RESULT_OFS:   ofs_r  = value;
            default: ;
        endcase
    endtask

    // Write the whole register file; call only while the scanner is idle
    task automatic load_setup(input logic [63:0] lo_w, input logic [63:0] hi_w,
                              input logic [63:0] care_w, input logic [63:0] len_w,
                              input logic [63:0] occ_w, input logic [63:0] base_w,
                              input logic [63:0] ofs_w);
        write_reg(REG_PATTERN_LOW,  lo_w);
        write_reg(REG_PATTERN_HIGH, hi_w);
        write_reg(REG_CARE_MASK,    care_w);
        write_reg(REG_PATTERN_LEN,  len_w);
        write_reg(REG_OCCURRENCE,   occ_w);
        write_reg(REG_BASE_ADDR,    base_w);
        write_reg(REG_RESULT_OFS,   ofs_w);
        cfg_wr_en <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Registers at reset value: length 0 never matches, so only not-found
    task automatic test_zero_length();
        stream_q = '{8'h00, 8'hFF};
        send_stream();
    endtask

    // One-byte stream whose only byte completes the match; address wraps past 2^64
    task automatic test_match_on_last_byte();
        settle();
        load_setup(64'hA5, 64'h0, 64'h3, 64'd1, 64'd0, '1, 64'd2);
        stream_q = '{8'hA5};
        send_stream();
    endtask

    // Full 16-byte pattern of extreme bytes; the trailing byte is ignored
    // and the stream end gives no not-found
    task automatic test_full_length_pattern();
        int k;
        settle();
        load_setup(64'hFF00_FF00_FF00_FF00, 64'hFF00_FF00_FF00_FF00, 64'hFFFF_FFFF,
                   64'd16, 64'd0, 64'd0, '1);
        stream_q.delete();
        for (k = 0; k < SCAN_SLOTS; k++) stream_q = {stream_q, pattern_at(k)};
        stream_q = {stream_q, 8'h5A};
        send_stream();
    endtask

    // Pattern 3? ?C with overlapping hits; report the second one.
    // Junk above the care mask width must be dropped.
    task automatic test_overlap_wildcards();
        settle();
        load_setup(64'h0C30, 64'h0, 64'hFFFF_FFFF_0000_0006, 64'd2, 64'd1,
                   64'h1000, 64'h0);
        stream_q = '{8'h3C, 8'h3C, 8'h3C};
        send_stream();
    endtask

    // Over-long pattern never matches; a stream shorter than the pattern neither
    task automatic test_rejected_lengths();
        settle();
        load_setup(64'h0, 64'h0, 64'h0, 64'd20, 64'd0, 64'h40, 64'h0);
        stream_q = '{8'hAA, 8'h55};
        send_stream();
        settle();
        load_setup(64'h0, 64'h0, 64'h0, 64'd3, 64'd0, 64'h40, 64'h0);
        stream_q = '{8'h12, 8'hED};
        send_stream();
    endtask

    // Every byte matches a one-byte all-wildcard pattern; the requested
    // occurrence is reached on the final byte of a long stream sent without gaps
    task automatic test_occurrence_limit();
        int j;
        settle();
        load_setup({$urandom, $urandom}, {$urandom, $urandom}, 64'h0, 64'd1,
                   64'(LIMIT_STREAM - 1),
                   {$urandom, $urandom}, {$urandom, $urandom});
        stream_q.delete();
        for (j = 0; j < LIMIT_STREAM; j++) stream_q = {stream_q, 8'($urandom)};
        tx_eager = 1'b1;
        send_stream();
        tx_eager = 1'b0;
    endtask

    // Random settings and streams; most streams carry planted pattern copies
    // with random content in the wildcard nibbles
    task automatic test_random_streams();
        int          sent;
        int          nstreams;
        int          s;
        int          k;
        int          target;
        int          plen;
        bit          plant;
        logic [7:0]  pat;
        logic [7:0]  mask;
        logic [7:0]  fill;
        logic [63:0] care_w;
        logic [63:0] len_w;
        logic [63:0] occ_w;
        logic [63:0] base_w;
        logic [63:0] ofs_w;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 3))
                0:       care_w = {$urandom, 32'hFFFF_FFFF};
                1:       care_w = {$urandom, 32'h0};
                default: care_w = {$urandom, $urandom};
            endcase
            case ($urandom_range(0, 9))
                0:       len_w = 64'd0;
                1:       len_w = 64'd16;
                2:       len_w = 64'($urandom_range(17, 31));
                3:       len_w = {$urandom, $urandom};
                default: len_w = 64'($urandom_range(1, 6));
            endcase
            case ($urandom_range(0, 7))
                0:       occ_w = 64'hFFFF;
                1:       occ_w = {$urandom, $urandom};
                default: occ_w = 64'($urandom_range(0, 3));
            endcase
            case ($urandom_range(0, 3))
                0:       base_w = '0;
                1:       base_w = '1;
                default: base_w = {$urandom, $urandom};
            endcase
            case ($urandom_range(0, 3))
                0:       ofs_w = '0;
                1:       ofs_w = '1;
                default: ofs_w = {$urandom, $urandom};
            endcase

            settle();
            load_setup({$urandom, $urandom}, {$urandom, $urandom}, care_w, len_w,
                       occ_w, base_w, ofs_w);
            tx_eager = ($urandom_range(0, 4) == 0);
            rx_eager = ($urandom_range(0, 4) == 0);

            plen = (len_r > SCAN_SLOTS) ? SCAN_SLOTS : int'(len_r);
            nstreams = $urandom_range(1, 3);
            for (s = 0; s < nstreams; s++) begin
                target = $urandom_range(1, (len_r > 8) ? 36 : 20);
                plant  = ($urandom_range(0, 5) != 0);
                stream_q.delete();
                while (stream_q.size() < target) begin
                    if (plant && plen != 0 && $urandom_range(0, 2) == 0) begin
                        for (k = 0; k < plen; k++) begin
                            pat  = pattern_at(k);
                            mask = {{4{care_r[2*k+1]}}, {4{care_r[2*k]}}};
                            fill = 8'($urandom);
                            stream_q = {stream_q, (pat & mask) | (fill & ~mask)};
                        end
                    end else begin
                        stream_q = {stream_q, 8'($urandom)};
                    end
                end
                sent += stream_q.size();
                send_stream();
                // Now and then stop feeding until every report is in
                if ($urandom_range(0, 7) == 0) settle();
            end
        end
        tx_eager = 1'b0;
        rx_eager = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Sequence and end of run
    // ------------------------------------------------------------------
    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        test_zero_length();
        test_match_on_last_byte();
        test_full_length_pattern();
        test_overlap_wildcards();
        test_rejected_lengths();
        test_occurrence_limit();
        test_random_streams();

        settle();
        if (mismatch_count == 0 && reports_due.size() == 0) begin
            $display("wildcard_nibble_pattern_scanner_unit_tb passed");
        end else begin
            $display("wildcard_nibble_pattern_scanner_unit_tb failed");
        end
        $finish;
    end

    // Stop a hung run; a missing report also ends up here
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("wildcard_nibble_pattern_scanner_unit_tb failed");
        $finish;
    end

endmodule

/* wildcard_nibble_pattern_scanner_unit.f */
sv/wnps_pkg.sv
sv/wnps_match.sv
sv/wnps_result_pipe.sv
sv/wildcard_nibble_pattern_scanner_unit.sv
dv/wildcard_nibble_pattern_scanner_unit_tb.sv
